FILE: design/i2crm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2crm_pkg
// shared types and constants of the i2c register master: command codes,
// the tick and result payloads and the reset values of the settings
// ----------------------------------------------------------------------------
package i2crm_pkg;

   // command carried with each tick
   typedef enum logic [1:0] {
      ACT_TICK  = 2'd0,
      ACT_READ  = 2'd1,
      ACT_WRITE = 2'd2,
      ACT_PROBE = 2'd3
   } action_type;

   localparam int unsigned DELAY_W         = 16;
   localparam int unsigned CNT_W           = 16;
   localparam int unsigned ACK_W           = 4;
   localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd10;
   localparam int unsigned ACK_RETRIES_DEF = 10;
   localparam int unsigned COUNT_BITS_DEF  = 16;

   // one bus tick with its command and line sample
   typedef struct packed {
      action_type        action;
      logic [6:0]        device_addr;
      logic [15:0]       reg_addr;
      logic              reg_wide;
      logic [CNT_W-1:0]  byte_count;
      logic [7:0]        write_data;
      logic              write_valid;
      logic              sda_in;
   } req_type;

   // line drive and status after one tick
   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       busy_res;
      logic       write_request;
      logic [7:0] read_data;
      logic       read_valid;
      logic       read_last;
      logic       done_res;
      logic       status;
   } rsp_type;

endpackage
`default_nettype wire

FILE: design/i2crm_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2crm_engine
// bus sequencer: holds the transaction state and advances it by one tick
// whenever step is high, giving the line drive and status of that tick
// ----------------------------------------------------------------------------
module i2crm_engine #(
   parameter int unsigned ACK_RETRIES = i2crm_pkg::ACK_RETRIES_DEF,
   parameter int unsigned COUNT_BITS  = i2crm_pkg::COUNT_BITS_DEF
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                step,
   input  wire i2crm_pkg::req_type            item,
   input  wire [i2crm_pkg::DELAY_W-1:0]       delay_ticks,
   output i2crm_pkg::rsp_type                 result
);

   typedef enum logic [24:0] {
      PH_IDLE       = 25'h0000001,
      PH_ST1        = 25'h0000002,
      PH_ST2        = 25'h0000004,
      PH_TX_BIT     = 25'h0000008,
      PH_TX_CLK     = 25'h0000010,
      PH_TX_AFTER   = 25'h0000020,
      PH_ACK_REL    = 25'h0000040,
      PH_ACK_CLK    = 25'h0000080,
      PH_ACK_SAMPLE = 25'h0000100,
      PH_ACK_OK     = 25'h0000200,
      PH_ACK_FAIL   = 25'h0000400,
      PH_NEXT       = 25'h0000800,
      PH_WAIT_DATA  = 25'h0001000,
      PH_RX_START   = 25'h0002000,
      PH_RX_CLK     = 25'h0004000,
      PH_RX_SAMPLE  = 25'h0008000,
      PH_RX_REPLY   = 25'h0010000,
      PH_M_CLK      = 25'h0020000,
      PH_M_LOW      = 25'h0040000,
      PH_M_REL      = 25'h0080000,
      PH_STOP1      = 25'h0100000,
      PH_STOP2      = 25'h0200000,
      PH_STOP2E     = 25'h0400000,
      PH_END_OK     = 25'h0800000,
      PH_END_ERR    = 25'h1000000
   } phase_type;

   // which byte of the transaction is on the wire
   typedef enum logic [2:0] {
      STG_DEVICE = 3'd0,
      STG_REG_HI = 3'd1,
      STG_REG_LO = 3'd2,
      STG_RD_DEV = 3'd3,
      STG_DATA   = 3'd4
   } stage_type;

   localparam int unsigned DW = i2crm_pkg::DELAY_W;
   localparam int unsigned AW = i2crm_pkg::ACK_W;

   phase_type               phase_ff, phase_in;
   stage_type               stage_ff, stage_in;
   i2crm_pkg::action_type   kind_ff, kind_in;
   logic [DW-1:0]           wait_ff, wait_in;
   logic [2:0]              bit_ff, bit_in;
   logic [7:0]              shift_ff, shift_in;
   logic [COUNT_BITS-1:0]   left_ff, left_in;
   logic [AW-1:0]           tries_ff, tries_in;
   logic [6:0]              dev_ff, dev_in;
   logic [15:0]             reg_ff, reg_in;
   logic                    wide_ff, wide_in;
   logic                    scl_ff, scl_in;
   logic                    sda_ff, sda_in;

   logic                    go_en, go_scl, go_sda, tx_go, do_wait, do_dos;
   phase_type               go_phase;
   logic [DW-1:0]           delay_len;

   // a zero delay behaves as one tick
   assign delay_len = (delay_ticks == '0) ? '0 : delay_ticks - DW'(1);

   always_comb begin
      phase_in = phase_ff;
      stage_in = stage_ff;
      kind_in  = kind_ff;
      wait_in  = wait_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      left_in  = left_ff;
      tries_in = tries_ff;
      dev_in   = dev_ff;
      reg_in   = reg_ff;
      wide_in  = wide_ff;
      scl_in   = scl_ff;
      sda_in   = sda_ff;
      go_en    = 1'b0;
      go_scl   = 1'b0;
      go_sda   = 1'b0;
      go_phase = PH_IDLE;
      tx_go    = 1'b0;
      do_wait  = 1'b0;
      do_dos   = 1'b0;
      result   = '0;

      if (phase_ff == PH_IDLE) begin
         if (item.action != i2crm_pkg::ACT_TICK) begin
            kind_in  = item.action;
            dev_in   = item.device_addr;
            reg_in   = item.reg_addr;
            wide_in  = item.reg_wide;
            left_in  = item.byte_count[COUNT_BITS-1:0];
            stage_in = STG_DEVICE;
            shift_in = {item.device_addr, 1'b0};
            bit_in   = 3'd7;
            go_en = 1'b1; go_scl = 1'b1; go_sda = 1'b1; go_phase = PH_ST1;
         end
      end else if (wait_ff != '0) begin
         wait_in = wait_ff - DW'(1);
      end else begin
         case (phase_ff)
            PH_ST1: begin
               go_en = 1'b1; go_scl = 1'b1; go_sda = 1'b0; go_phase = PH_ST2;
            end
            PH_ST2: begin
               go_en = 1'b1; go_scl = 1'b0; go_sda = 1'b0; go_phase = PH_TX_BIT;
            end
            PH_TX_BIT: tx_go = 1'b1;
            PH_TX_CLK: begin
               go_en = 1'b1; go_scl = 1'b1; go_sda = sda_ff; go_phase = PH_TX_AFTER;
            end
            PH_TX_AFTER: begin
               if (bit_ff == 3'd0) begin
                  go_en = 1'b1; go_scl = 1'b0; go_sda = sda_ff; go_phase = PH_ACK_REL;
               end else begin
                  bit_in = bit_ff - 3'd1;
                  tx_go  = 1'b1;
               end
            end
            PH_ACK_REL: begin
               go_en = 1'b1; go_scl = scl_ff; go_sda = 1'b1; go_phase = PH_ACK_CLK;
            end
            PH_ACK_CLK: begin
               tries_in = AW'(ACK_RETRIES);
               go_en = 1'b1; go_scl = 1'b1; go_sda = 1'b1; go_phase = PH_ACK_SAMPLE;
            end
            PH_ACK_SAMPLE: begin
               go_en = 1'b1; go_sda = 1'b1;
               if (!item.sda_in) begin
                  go_scl = 1'b0; go_phase = PH_ACK_OK;
               end else if (tries_ff != '0) begin
                  tries_in = tries_ff - AW'(1);
                  go_scl = 1'b1; go_phase = PH_ACK_SAMPLE;
               end else begin
                  go_scl = 1'b0; go_phase = PH_ACK_FAIL;
               end
            end
            PH_ACK_OK: begin
               go_en = 1'b1;
               if (kind_ff == i2crm_pkg::ACT_PROBE) begin
                  go_scl = 1'b1; go_sda = 1'b0; go_phase = PH_STOP2;
               end else begin
                  go_scl = 1'b0; go_sda = 1'b1; go_phase = PH_NEXT;
               end
            end
            PH_ACK_FAIL: begin
               if (kind_ff == i2crm_pkg::ACT_PROBE) begin
                  go_en = 1'b1; go_scl = 1'b1; go_sda = 1'b0; go_phase = PH_STOP2E;
               end else begin
                  // no stop: lines stay as they are
                  phase_in        = PH_IDLE;
                  wait_in         = '0;
                  result.done_res = 1'b1;
                  result.status   = 1'b1;
               end
            end
            PH_NEXT: begin
               case (stage_ff)
                  STG_DEVICE: begin
                     bit_in = 3'd7;
                     tx_go  = 1'b1;
                     if (wide_ff) begin
                        shift_in = reg_ff[15:8];
                        stage_in = STG_REG_HI;
                     end else begin
                        shift_in = reg_ff[7:0];
                        stage_in = STG_REG_LO;
                     end
                  end
                  STG_REG_HI: begin
                     shift_in = reg_ff[7:0];
                     bit_in   = 3'd7;
                     stage_in = STG_REG_LO;
                     tx_go    = 1'b1;
                  end
                  STG_REG_LO: begin
                     if (kind_ff == i2crm_pkg::ACT_READ) begin
                        // repeated start with the read address
                        stage_in = STG_RD_DEV;
                        shift_in = {dev_ff, 1'b1};
                        bit_in   = 3'd7;
                        go_en = 1'b1; go_scl = 1'b1; go_sda = 1'b1; go_phase = PH_ST1;
                     end else begin
                        do_dos = 1'b1;
                     end
                  end
                  STG_RD_DEV: begin
                     if (left_ff == '0) begin
                        go_en = 1'b1; go_scl = 1'b1; go_sda = 1'b0; go_phase = PH_STOP2;
                     end else begin
                        shift_in = '0;
                        bit_in   = 3'd7;
                        go_en = 1'b1; go_scl = 1'b1; go_sda = 1'b1;
                        go_phase = PH_RX_SAMPLE;
                     end
                  end
                  default: do_dos = 1'b1;
               endcase
            end
            PH_WAIT_DATA: do_wait = 1'b1;
            PH_RX_START: begin
               shift_in = '0;
               bit_in   = 3'd7;
               go_en = 1'b1; go_scl = 1'b1; go_sda = 1'b1; go_phase = PH_RX_SAMPLE;
            end
            PH_RX_CLK: begin
               go_en = 1'b1; go_scl = 1'b1; go_sda = 1'b1; go_phase = PH_RX_SAMPLE;
            end
            PH_RX_SAMPLE: begin
               shift_in[bit_ff] = shift_ff[bit_ff] | item.sda_in;
               go_en = 1'b1; go_scl = 1'b0; go_sda = 1'b1;
               if (bit_ff == 3'd0) begin
                  result.read_valid = 1'b1;
                  result.read_data  = shift_in;
                  result.read_last  = (left_ff <= COUNT_BITS'(1));
                  left_in  = left_ff - COUNT_BITS'(1);
                  go_phase = PH_RX_REPLY;
               end else begin
                  bit_in   = bit_ff - 3'd1;
                  go_phase = PH_RX_CLK;
               end
            end
            PH_RX_REPLY: begin
               // ack unless that was the last byte
               go_en = 1'b1; go_scl = 1'b0; go_sda = (left_ff == '0); go_phase = PH_M_CLK;
            end
            PH_M_CLK: begin
               go_en = 1'b1; go_scl = 1'b1; go_sda = sda_ff; go_phase = PH_M_LOW;
            end
            PH_M_LOW: begin
               go_en = 1'b1; go_scl = 1'b0; go_sda = sda_ff;
               go_phase = (left_ff != '0) ? PH_M_REL : PH_STOP1;
            end
            PH_M_REL: begin
               go_en = 1'b1; go_scl = 1'b0; go_sda = 1'b1; go_phase = PH_RX_START;
            end
            PH_STOP1: begin
               go_en = 1'b1; go_scl = 1'b1; go_sda = 1'b0; go_phase = PH_STOP2;
            end
            PH_STOP2: begin
               go_en = 1'b1; go_scl = 1'b1; go_sda = 1'b1; go_phase = PH_END_OK;
            end
            PH_STOP2E: begin
               go_en = 1'b1; go_scl = 1'b1; go_sda = 1'b1; go_phase = PH_END_ERR;
            end
            PH_END_OK: begin
               phase_in        = PH_IDLE;
               wait_in         = '0;
               result.done_res = 1'b1;
               result.status   = 1'b0;
            end
            PH_END_ERR: begin
               phase_in        = PH_IDLE;
               wait_in         = '0;
               result.done_res = 1'b1;
               result.status   = 1'b1;
            end
            default: begin
               phase_in = PH_IDLE;
               wait_in  = '0;
            end
         endcase
      end

      // more data or stop
      if (do_dos) begin
         if (left_ff == '0) begin
            go_en = 1'b1; go_scl = 1'b1; go_sda = 1'b0; go_phase = PH_STOP2;
         end else begin
            do_wait = 1'b1;
         end
      end

      // ask for the next write byte, take it when offered
      if (do_wait) begin
         phase_in             = PH_WAIT_DATA;
         wait_in              = '0;
         result.write_request = 1'b1;
         if (item.write_valid) begin
            left_in  = left_ff - COUNT_BITS'(1);
            shift_in = item.write_data;
            bit_in   = 3'd7;
            stage_in = STG_DATA;
            tx_go    = 1'b1;
         end
      end

      if (go_en) begin
         scl_in   = go_scl;
         sda_in   = go_sda;
         wait_in  = delay_len;
         phase_in = go_phase;
      end

      // drive the current bit with scl low
      if (tx_go) begin
         scl_in   = 1'b0;
         sda_in   = shift_in[bit_in];
         wait_in  = delay_len;
         phase_in = PH_TX_CLK;
      end

      result.scl_out  = scl_in;
      result.sda_out  = sda_in;
      result.busy_res = (phase_in != PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         stage_ff <= STG_DEVICE;
         kind_ff  <= i2crm_pkg::ACT_TICK;
         wait_ff  <= '0;
         bit_ff   <= 3'd7;
         shift_ff <= '0;
         left_ff  <= '0;
         tries_ff <= '0;
         dev_ff   <= '0;
         reg_ff   <= '0;
         wide_ff  <= 1'b0;
         scl_ff   <= 1'b1;
         sda_ff   <= 1'b1;
      end else if (step) begin
         phase_ff <= phase_in;
         stage_ff <= stage_in;
         kind_ff  <= kind_in;
         wait_ff  <= wait_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         left_ff  <= left_in;
         tries_ff <= tries_in;
         dev_ff   <= dev_in;
         reg_ff   <= reg_in;
         wide_ff  <= wide_in;
         scl_ff   <= scl_in;
         sda_ff   <= sda_in;
      end
   end

endmodule
`default_nettype wire

FILE: design/i2c_register_master_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_register_master_unit
// open-drain i2c master for register reads, register writes and probes
// ----------------------------------------------------------------------------
// usage
//  - every req transfer is one bus tick: it carries a command (honoured only
//    while idle), the offered write byte and the sampled sda level
//  - every req transfer yields exactly one rsp transfer with the scl/sda
//    drive, busy, the write byte request, a read byte and done/status
//  - csr carries delay_ticks, the length of each bus delay in ticks; write
//    it only while no transaction is running
//  - a tick passes through the input register and then into the output
//    register; throughput is one tick per clock cycle while rsp is not
//    stalled, set by the input register feeding the sequencer step
//  - a stalled rsp holds its result; the input register still takes one
//    more tick, after which req_stall rises until rsp moves again
//  - reset: bus released (scl and sda high), sequencer idle, both registers
//    empty, delay_ticks back to ten
// ----------------------------------------------------------------------------
module i2c_register_master_unit #(
   parameter int unsigned ACK_RETRIES = i2crm_pkg::ACK_RETRIES_DEF,
   parameter int unsigned COUNT_BITS  = i2crm_pkg::COUNT_BITS_DEF
) (
   input  wire                              clock,
   input  wire                              reset,
   // tick channel
   input  wire                              req_valid,
   output logic                             req_stall,
   input  wire i2crm_pkg::req_type          req_data,
   // result channel
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output i2crm_pkg::rsp_type               rsp_data,
   // settings channel
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire [i2crm_pkg::DELAY_W-1:0]     csr_data
);

   i2crm_pkg::req_type                 item_ff;
   logic                               item_valid_ff, item_valid_in;
   i2crm_pkg::rsp_type                 rsp_ff, step_result;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [i2crm_pkg::DELAY_W-1:0]      delay_ff;
   logic                               advance, req_take;

   // the held tick moves on when the output register is free or emptying
   assign advance   = item_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = item_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign item_valid_in = req_take || (item_valid_ff && !advance);
   assign rsp_valid_in  = advance || (rsp_valid_ff && rsp_stall);

   // settings are always taken
   assign csr_ready = 1'b1;

   i2crm_engine #(
      .ACK_RETRIES (ACK_RETRIES),
      .COUNT_BITS  (COUNT_BITS)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .item        (item_ff),
      .delay_ticks (delay_ff),
      .result      (step_result)
   );

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
      if (req_take) begin
         item_ff <= req_data;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (advance) begin
         rsp_ff <= step_result;
      end
   end

   // delay setting
   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff <= i2crm_pkg::DELAY_RESET;
      end else if (csr_valid && csr_ready) begin
         delay_ff <= csr_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire
